FILE: hdl/lph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table package
// Shared sizes, status codes and the item type for the hash table.
// ----------------------------------------------------------------------------
package lph_pkg;
  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t          op;
    logic [63:0]      key;
    logic [63:0]      value;
    logic [IDX_W-1:0] start;
  } job_t;
endpackage

FILE: hdl/lph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/lph_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table front end
// Accepts items, mixes the key in a pipeline and queues them for the back end.
// ----------------------------------------------------------------------------
module lph_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_opcode,
  input  logic [63:0]   in_lookup_key,
  input  logic [63:0]   in_write_value,
  output logic          job_valid,
  output lph_pkg::job_t job,
  input  logic          job_take
);
  import lph_pkg::*;

  localparam int unsigned QD = 2;
  localparam int unsigned NS = 7;

  // Seven-stage mixer: xor-shift, then each multiply as a stage of 32-bit
  // partial products and a stage that sums them, each followed by an xor-shift.
  logic [NS-1:0] v_r;
  job_t          j_r [NS];
  logic [63:0]   m0_r, m1_r, m2_r, m3_r, m4_r;
  logic [63:0]   pa_ll_r, pb_ll_r;
  logic [31:0]   pa_cr_r, pb_cr_r;
  logic [63:0]   k0;
  job_t          jin;
  job_t          jq;
  logic          adv;

  job_t          q_r [QD];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          rd_r, wr_r;
  logic          push_q, pop_q;
  logic [3:0]    inflight;

  assign inflight = 4'($countones(v_r));
  // Admit only if a queue place is reserved for every item in the mixer.
  assign in_full = (4'(cnt_r) + inflight) >= 4'(QD);
  assign adv = in_push && !in_full;

  assign k0 = in_lookup_key ^ (in_lookup_key >> 33);
  always_comb begin
    jin       = '0;
    jin.op    = opcode_t'(in_opcode);
    jin.key   = in_lookup_key;
    jin.value = in_write_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-2:0], adv};
    end
    m0_r    <= k0;
    pa_ll_r <= 64'(m0_r[31:0]) * 64'(MIX_C1[31:0]);
    pa_cr_r <= m0_r[63:32] * MIX_C1[31:0] + m0_r[31:0] * MIX_C1[63:32];
    m1_r    <= pa_ll_r + {pa_cr_r, 32'd0};
    m2_r    <= m1_r ^ (m1_r >> 33);
    pb_ll_r <= 64'(m2_r[31:0]) * 64'(MIX_C2[31:0]);
    pb_cr_r <= m2_r[63:32] * MIX_C2[31:0] + m2_r[31:0] * MIX_C2[63:32];
    m3_r    <= pb_ll_r + {pb_cr_r, 32'd0};
    m4_r    <= m3_r ^ (m3_r >> 33);
    j_r[0]  <= jin;
    for (int i = 1; i < NS; i++) begin
      j_r[i] <= j_r[i-1];
    end
  end

  always_comb begin
    jq       = j_r[NS-1];
    jq.start = m4_r[IDX_W-1:0];
  end

  always_comb begin
    push_q = v_r[NS-1];
    pop_q  = job_take && (cnt_r != 2'd0);
    cnt_nxt = cnt_r + 2'(push_q) - 2'(pop_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_q) begin
        wr_r <= ~wr_r;
      end
      if (pop_q) begin
        rd_r <= ~rd_r;
      end
    end
    if (push_q) begin
      q_r[wr_r] <= jq;
    end
  end

  assign job_valid = cnt_r != 2'd0;
  assign job       = q_r[rd_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QD)) else $error("queue overfilled");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (4'(cnt_r) + inflight) <= 4'(QD)) else $error("reservation broken");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("take from empty queue");
`endif
endmodule

FILE: hdl/lph_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table back end
// Walks the probe path in the slot stores and holds the result register.
// ----------------------------------------------------------------------------
module lph_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  lph_pkg::job_t job,
  output logic          job_take,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [1:0]    out_status,
  output logic [63:0]   out_read_value
);
  import lph_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_CLEAR
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  job_t              cur_r, cur_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              res_v_r, res_v_nxt;
  logic [1:0]        res_s_r, res_s_nxt;
  logic [63:0]       res_d_r, res_d_nxt;

  logic              we_key, we_val, we_occ;
  logic [IDX_W-1:0]  raddr, waddr;
  logic [63:0]       key_q, val_q;
  logic [0:0]        occ_q;
  logic [0:0]        occ_wd;
  logic              at_limit;

  lph_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
    .clk, .we(we_key), .waddr, .wdata(cur_r.key), .raddr, .rdata(key_q));
  lph_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (
    .clk, .we(we_val), .waddr, .wdata(cur_r.value), .raddr, .rdata(val_q));
  lph_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_occ (
    .clk, .we(we_occ), .waddr, .wdata(occ_wd), .raddr, .rdata(occ_q));

  assign at_limit = ({2'b0, count_r} << 2) >= (CNT_W+2)'(SLOTS * 3);
  assign raddr    = idx_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    count_nxt = count_r;
    res_v_nxt = res_v_r && !out_pop;
    res_s_nxt = res_s_r;
    res_d_nxt = res_d_r;
    job_take  = 1'b0;
    we_key    = 1'b0;
    we_val    = 1'b0;
    we_occ    = 1'b0;
    waddr     = idx_r;
    occ_wd    = 1'b1;
    unique case (state_r)
      BK_CLEAR: begin
        we_occ = 1'b1;
        occ_wd = 1'b0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (job_valid && !res_v_nxt) begin
          job_take = 1'b1;
          cur_nxt  = job;
          idx_nxt  = job.start;
          n_nxt    = '0;
          if (job.op == OP_INSERT && at_limit) begin
            res_v_nxt = 1'b1;
            res_s_nxt = ST_FULL;
            res_d_nxt = '0;
          end else begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ: begin
        state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        res_d_nxt = '0;
        res_s_nxt = ST_OK;
        if (!occ_q[0]) begin
          if (cur_r.op == OP_INSERT) begin
            we_key = 1'b1;
            we_val = 1'b1;
            we_occ = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            res_s_nxt = ST_MISS;
          end
          res_v_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end else if (key_q == cur_r.key) begin
          if (cur_r.op == OP_INSERT) begin
            we_val = 1'b1;
          end else begin
            res_d_nxt = val_q;
          end
          res_v_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end else if (n_r == CNT_W'(SLOTS - 1)) begin
          res_s_nxt = (cur_r.op == OP_INSERT) ? ST_FULL : ST_MISS;
          res_v_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          n_nxt     = n_r + 1'b1;
          state_nxt = BK_READ;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      idx_r   <= '0;
      count_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      res_v_r <= res_v_nxt;
    end
    cur_r   <= cur_nxt;
    n_r     <= n_nxt;
    res_s_r <= res_s_nxt;
    res_d_r <= res_d_nxt;
  end

  assign out_empty      = !res_v_r;
  assign out_status     = res_s_r;
  assign out_read_value = res_d_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS)) else $error("entry count out of range");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> state_r == BK_IDLE) else $error("take while busy");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> count_r == $past(count_r) + 1'b1)
    else $error("entry count jumped");
`endif
endmodule

FILE: hdl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table
// Flow: an item is hashed in the mixer, queued and issued to the back end,
// which reads and checks each probed slot; a refused insert is not probed.
// The back end takes one item at a time and takes no new item until its last
// result is popped; the front end holds at most two items, one per queue place.
// Reset: synchronous; a pass over all slots then clears the occupied marks,
// during which items queue but are not processed.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_opcode,
  input  logic [63:0] in_lookup_key,
  input  logic [63:0] in_write_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_value
);
  import lph_pkg::*;

  logic job_valid;
  logic job_take;
  job_t job;

  lph_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_opcode, .in_lookup_key,
    .in_write_value, .job_valid, .job, .job_take);

  lph_back u_back (
    .clk, .rst_n, .job_valid, .job, .job_take, .out_empty, .out_pop,
    .out_status, .out_read_value);
endmodule
